FILE: rtl/iso8601_to_epoch_ms_assert.svh
// Assertion macros used by the checker file of the timestamp converter.
// Each macro expands to one labeled concurrent assertion, clocked on the rising
// edge and disabled while the active-low reset is asserted.
`ifndef ISO8601_TO_EPOCH_MS_ASSERT_SVH
`define ISO8601_TO_EPOCH_MS_ASSERT_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define ISOEP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("isoep same-cycle check failed");

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define ISOEP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("isoep next-cycle check failed");

`endif

FILE: rtl/isoep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoep_pkg
// Shared types and constants of the timestamp text to epoch time converter.
// ----------------------------------------------------------------------------
package isoep_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned FIELD_W  = 7;
  localparam int unsigned EPOCH_W  = 49;
  localparam int unsigned DAYS_W   = 26;
  localparam int unsigned TODMS_W  = 29;

  // Character places of the separators, which also bound the digit fields.
  localparam logic [POS_W-1:0] POS_DASH0  = 5'd4;
  localparam logic [POS_W-1:0] POS_DASH1  = 5'd7;
  localparam logic [POS_W-1:0] POS_T      = 5'd10;
  localparam logic [POS_W-1:0] POS_COLON0 = 5'd13;
  localparam logic [POS_W-1:0] POS_COLON1 = 5'd16;
  localparam logic [POS_W-1:0] POS_Z      = 5'd19;
  localparam logic [POS_W-1:0] POS_LIMIT  = 5'd20;
  localparam logic [POS_W-1:0] POS_MAX    = 5'd31;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Calendar arithmetic constants.
  localparam int unsigned YEAR_BIAS     = 400;
  localparam int unsigned ERA_RECIP     = 41944;
  localparam int unsigned ERA_SHIFT     = 24;
  localparam int unsigned DIV5_RECIP    = 52429;
  localparam int unsigned DIV5_SHIFT    = 18;
  localparam int unsigned DIV100_RECIP  = 41;
  localparam int unsigned DIV100_SHIFT  = 12;
  localparam int unsigned DAYS_PER_ERA  = 146097;
  localparam int unsigned DAY_OFFSET    = 719468 + 146097;
  localparam int unsigned MS_PER_DAY    = 86400000;

  typedef struct packed {
    logic               ok;
    logic [YEAR_W-1:0]  year;
    logic [FIELD_W-1:0] month;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] second;
  } isoep_fields_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DAYS_W-1:0] days;
    logic [TODMS_W-1:0]       tod_ms;
  } isoep_days_t;

endpackage

FILE: rtl/isoep_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoep_parse
// Per-character parser: checks separators, digits and length, accumulates the
// decimal fields and hands the finished fields on when the last item arrives.
// ----------------------------------------------------------------------------
module isoep_parse import isoep_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic              last_i,
  output logic              fld_valid_o,
  input  logic              fld_ready_i,
  output isoep_fields_t     fld_o
);

  logic [POS_W-1:0]   pos_q, pos_d;
  logic               err_q, err_d;
  logic [YEAR_W-1:0]  year_q, year_d;
  logic [FIELD_W-1:0] month_q, month_d, day_q, day_d;
  logic [FIELD_W-1:0] hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic               fld_v_q, fld_v_d;
  isoep_fields_t      fld_q, fld_d;
  logic [CHAR_W-1:0]  sep;
  logic               is_digit;
  logic [3:0]         dig;
  logic               accept;
  logic               launch;

  function automatic logic [YEAR_W-1:0] acc14(input logic [YEAR_W-1:0] a,
                                              input logic [3:0] d);
    return {a[YEAR_W-4:0], 3'b000} + {a[YEAR_W-2:0], 1'b0} + {{(YEAR_W-4){1'b0}}, d};
  endfunction

  function automatic logic [FIELD_W-1:0] acc7(input logic [FIELD_W-1:0] a,
                                              input logic [3:0] d);
    return {a[FIELD_W-4:0], 3'b000} + {a[FIELD_W-2:0], 1'b0} + {{(FIELD_W-4){1'b0}}, d};
  endfunction

  assign in_ready_o  = !fld_v_q || fld_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign launch      = accept && last_i;
  assign fld_valid_o = fld_v_q;
  assign fld_o       = fld_q;

  always_comb begin
    case (pos_q)
      POS_DASH0, POS_DASH1:   sep = CHAR_DASH;
      POS_T:                  sep = CHAR_T;
      POS_COLON0, POS_COLON1: sep = CHAR_COLON;
      POS_Z:                  sep = CHAR_Z;
      default:                sep = CHAR_NONE;
    endcase
  end

  assign is_digit = char_code_i inside {[CHAR_ZERO:CHAR_NINE]};
  assign dig      = char_code_i[3:0];

  always_comb begin
    err_d    = err_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    if (pos_q >= POS_LIMIT) begin
      err_d = 1'b1;
    end else if (sep != CHAR_NONE) begin
      if (char_code_i != sep) begin
        err_d = 1'b1;
      end
    end else if (!is_digit) begin
      err_d = 1'b1;
    end else if (pos_q < POS_DASH0) begin
      year_d = acc14(year_q, dig);
    end else if (pos_q < POS_DASH1) begin
      month_d = acc7(month_q, dig);
    end else if (pos_q < POS_T) begin
      day_d = acc7(day_q, dig);
    end else if (pos_q < POS_COLON0) begin
      hour_d = acc7(hour_q, dig);
    end else if (pos_q < POS_COLON1) begin
      minute_d = acc7(minute_q, dig);
    end else begin
      second_d = acc7(second_q, dig);
    end
    pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;

    fld_d.ok     = !err_d && (pos_q == POS_Z);
    fld_d.year   = year_d;
    fld_d.month  = month_d;
    fld_d.day    = day_d;
    fld_d.hour   = hour_d;
    fld_d.minute = minute_d;
    fld_d.second = second_d;

    if (launch) begin
      fld_v_d = 1'b1;
    end else if (fld_ready_i) begin
      fld_v_d = 1'b0;
    end else begin
      fld_v_d = fld_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      err_q    <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      fld_v_q  <= 1'b0;
    end else begin
      fld_v_q <= fld_v_d;
      if (accept) begin
        if (last_i) begin
          pos_q    <= '0;
          err_q    <= 1'b0;
          year_q   <= '0;
          month_q  <= '0;
          day_q    <= '0;
          hour_q   <= '0;
          minute_q <= '0;
          second_q <= '0;
        end else begin
          pos_q    <= pos_d;
          err_q    <= err_d;
          year_q   <= year_d;
          month_q  <= month_d;
          day_q    <= day_d;
          hour_q   <= hour_d;
          minute_q <= minute_d;
          second_q <= second_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      fld_q <= fld_d;
    end
  end

endmodule

FILE: rtl/isoep_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoep_days
// Four-stage pipeline that turns the parsed fields into the day count since
// 1970-01-01 (civil-to-days rule, eras of 400 years) and the time of day in ms.
// ----------------------------------------------------------------------------
module isoep_days import isoep_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fld_valid_i,
  output logic          fld_ready_o,
  input  isoep_fields_t fld_i,
  output logic          days_valid_o,
  input  logic          days_ready_i,
  output isoep_days_t   days_o
);

  logic en_a, en_b, en_c, en_d;
  logic v_a_q, v_b_q, v_c_q, v_d_q;

  // Stage A: shifted year, era estimate, month product term, time of day.
  logic               low_month;
  logic [14:0]        yy_a;
  logic [30:0]        era_prod;
  logic [FIELD_W-1:0] mp_a;
  logic [14:0]        qnum_a;
  logic [18:0]        tod_a;
  logic               ok_a_q;
  logic [14:0]        yy_a_q;
  logic [5:0]         era_a_q;
  logic [14:0]        qnum_a_q;
  logic [FIELD_W-1:0] day_a_q;
  logic [18:0]        tod_a_q;

  // Stage B: year of era, day of year, time of day in ms.
  logic [14:0]        yoe_full;
  logic [30:0]        q5_prod;
  logic [12:0]        doy5;
  logic signed [13:0] doy_b;
  logic [TODMS_W-1:0] todms_b;
  logic               ok_b_q;
  logic [5:0]         era_b_q;
  logic [8:0]         yoe_b_q;
  logic signed [13:0] doy_b_q;
  logic [TODMS_W-1:0] todms_b_q;

  // Stage C: day of era and era offset.
  logic [17:0]        y365;
  logic [14:0]        y41;
  logic signed [19:0] doe_c;
  logic [23:0]        era_term_c;
  logic               ok_c_q;
  logic signed [19:0] doe_c_q;
  logic [23:0]        era_term_c_q;
  logic [TODMS_W-1:0] todms_c_q;

  // Stage D: day count.
  logic signed [DAYS_W-1:0] days_d;
  isoep_days_t              out_q;

  assign en_d        = !v_d_q || days_ready_i;
  assign en_c        = !v_c_q || en_d;
  assign en_b        = !v_b_q || en_c;
  assign en_a        = !v_a_q || en_b;
  assign fld_ready_o = en_a;

  always_comb begin
    low_month = (fld_i.month <= 7'd2);
    yy_a      = {1'b0, fld_i.year} + 15'(YEAR_BIAS) - {14'b0, low_month};
    era_prod  = 31'(yy_a) * 31'(ERA_RECIP);
    mp_a      = low_month ? fld_i.month + 7'd9 : fld_i.month - 7'd3;
    qnum_a    = 15'(mp_a) * 15'd153 + 15'd2;
    tod_a     = 19'(fld_i.hour) * 19'd3600 + 19'(fld_i.minute) * 19'd60
              + 19'(fld_i.second);
  end

  always_comb begin
    yoe_full = yy_a_q - 15'(era_a_q) * 15'(YEAR_BIAS);
    q5_prod  = 31'(qnum_a_q) * 31'(DIV5_RECIP);
    doy5     = q5_prod[DIV5_SHIFT+12:DIV5_SHIFT];
    doy_b    = $signed({1'b0, doy5}) + $signed({7'b0, day_a_q}) - 14'sd1;
    todms_b  = 29'(tod_a_q) * 29'd1000;
  end

  always_comb begin
    y365       = 18'(yoe_b_q) * 18'd365;
    y41        = 15'(yoe_b_q) * 15'(DIV100_RECIP);
    doe_c      = $signed(20'(y365)) + $signed(20'(yoe_b_q[8:2]))
               - $signed(20'(y41[DIV100_SHIFT+2:DIV100_SHIFT])) + 20'(doy_b_q);
    era_term_c = 24'(era_b_q) * 24'(DAYS_PER_ERA);
  end

  assign days_d = $signed(26'(era_term_c_q)) + 26'(doe_c_q) - 26'(DAY_OFFSET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
      v_d_q <= 1'b0;
    end else begin
      if (en_a) begin
        v_a_q <= fld_valid_i;
      end
      if (en_b) begin
        v_b_q <= v_a_q;
      end
      if (en_c) begin
        v_c_q <= v_b_q;
      end
      if (en_d) begin
        v_d_q <= v_c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      ok_a_q   <= fld_i.ok;
      yy_a_q   <= yy_a;
      era_a_q  <= era_prod[ERA_SHIFT+5:ERA_SHIFT];
      qnum_a_q <= qnum_a;
      day_a_q  <= fld_i.day;
      tod_a_q  <= tod_a;
    end
    if (en_b) begin
      ok_b_q    <= ok_a_q;
      era_b_q   <= era_a_q;
      yoe_b_q   <= yoe_full[8:0];
      doy_b_q   <= doy_b;
      todms_b_q <= todms_b;
    end
    if (en_c) begin
      ok_c_q       <= ok_b_q;
      doe_c_q      <= doe_c;
      era_term_c_q <= era_term_c;
      todms_c_q    <= todms_b_q;
    end
    if (en_d) begin
      out_q.ok     <= ok_c_q;
      out_q.days   <= days_d;
      out_q.tod_ms <= todms_c_q;
    end
  end

  assign days_valid_o = v_d_q;
  assign days_o       = out_q;

endmodule

FILE: rtl/iso8601_to_epoch_ms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_to_epoch_ms
// Converts a UTC timestamp text "YYYY-MM-DDTHH:MM:SSZ" into epoch milliseconds.
// ----------------------------------------------------------------------------
// Input channel: one ASCII character per item on char_code_i, with last_i high
// on the final character. Output channel: one result per text, valid_res_o
// tells whether length, separators and digits were correct, and epoch_ms_o
// holds the signed millisecond count (zero for an invalid text).
// Throughput is one character per cycle; the parser accepts a new character
// in every cycle while the result pipeline has room.
// The result passes through the field register, four calendar stages and the
// output register, which holds the final multiply by the day length.
// Reset clears the character position, error flag, accumulators and all valid
// flags; the block starts a fresh text at once.
// When the receiver stalls, the result holds in the output register and the
// pipeline stages behind it keep filling; input items stop being accepted only
// once every stage holds a pending result.
module iso8601_to_epoch_ms import isoep_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CHAR_W-1:0]         char_code_i,
  input  logic                      last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      valid_res_o,
  output logic signed [EPOCH_W-1:0] epoch_ms_o
);

  localparam logic signed [27:0] DAY_MS = 28'(MS_PER_DAY);

  logic                      fld_valid, fld_ready;
  isoep_fields_t             fld;
  logic                      days_valid, days_ready;
  isoep_days_t               days;
  logic signed [53:0]        ms_full;
  logic                      out_v_q;
  logic                      valid_res_q;
  logic signed [EPOCH_W-1:0] epoch_q, epoch_d;

  isoep_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .fld_valid_o (fld_valid),
    .fld_ready_i (fld_ready),
    .fld_o       (fld)
  );

  isoep_days u_days (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fld_valid_i  (fld_valid),
    .fld_ready_o  (fld_ready),
    .fld_i        (fld),
    .days_valid_o (days_valid),
    .days_ready_i (days_ready),
    .days_o       (days)
  );

  assign days_ready = !out_v_q || out_ready_i;

  always_comb begin
    ms_full = 54'(days.days) * 54'(DAY_MS) + $signed(54'(days.tod_ms));
    epoch_d = days.ok ? ms_full[EPOCH_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (days_ready) begin
      out_v_q <= days_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (days_ready) begin
      valid_res_q <= days.ok;
      epoch_q     <= epoch_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign valid_res_o = valid_res_q;
  assign epoch_ms_o  = epoch_q;

endmodule

FILE: rtl/isoep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isoep_checker
// Port-level checks of the timestamp converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "iso8601_to_epoch_ms_assert.svh"

module isoep_checker import isoep_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic                      valid_res_i,
  input logic signed [EPOCH_W-1:0] epoch_ms_i
);

  `ISOEP_ASSERT_IMP(a_invalid_zero, clk_i, rst_ni, out_valid_i && !valid_res_i, epoch_ms_i == '0)
  `ISOEP_ASSERT_IMP(a_epoch_range, clk_i, rst_ni, out_valid_i && valid_res_i, (epoch_ms_i >= -49'sd62169984000000) && (epoch_ms_i <= 49'sd253638535239000))
  `ISOEP_ASSERT_IMP(a_stall_only_back, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)
  `ISOEP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(epoch_ms_i) && $stable(valid_res_i))

endmodule

bind iso8601_to_epoch_ms isoep_checker u_isoep_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .valid_res_i (valid_res_o),
  .epoch_ms_i  (epoch_ms_o)
);
